// File: src/periodic_task_release_scheduler_assert.svh
// Assertion macros shared by the checker of the periodic task release scheduler.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTRS_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTRS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/ptrs_pkg.sv
// Package of the periodic task release scheduler: defaults, codes and result type.
`timescale 1ns / 1ps

package ptrs_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [15:0] TICK_LIMIT_RST = 16'd10;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SERVICE = 2'd1;
    localparam logic [1:0] CMD_ADD     = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [2:0] KIND_RELEASE  = 3'd0;
    localparam logic [2:0] KIND_ADD_OK   = 3'd1;
    localparam logic [2:0] KIND_ADD_FAIL = 3'd2;
    localparam logic [2:0] KIND_ACK      = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tag;
        logic [2:0] slot;
        logic       last;
    } t_res;

endpackage

// File: src/ptrs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ptrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/periodic_task_release_scheduler.sv
// Periodic task release scheduler: task table, pending tick count and release walk.
// A tick, a restart, nothing pending or a zero period goes from idle straight to the emit
// state; an add searches the table one slot a cycle; a service walks every slot one slot a
// cycle through the shared countdown unit, broken off to emit an earlier release when another
// is found. A new item is taken only in idle, and output stalls hold the emit state longer.
// Synchronous active-low reset empties the table, clears the count and the flag, tick_limit 10.
`timescale 1ns / 1ps

module periodic_task_release_scheduler #(
    parameter int NUM_SLOTS  = ptrs_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = ptrs_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick_limit_we,
    input  logic [15:0] i_tick_limit,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_task_tag,
    input  logic [15:0] i_first_delay,
    input  logic [15:0] i_period,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_task_tag_res,
    output logic [2:0]  o_slot,
    output logic [15:0] o_pending,
    output logic        o_overrun,
    output logic        o_last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENT_W = 8 + 2 * COUNT_BITS;
    localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(NUM_SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FIND  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_used, n_used;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [COUNT_BITS-1:0] r_pending, n_pending;
    logic                  r_overrun, n_overrun;
    logic [15:0]           r_tick_limit;
    ptrs_pkg::t_res        r_res, n_res;
    ptrs_pkg::t_res        r_hold, n_hold;
    logic                  r_hold_v, n_hold_v;
    logic                  r_walk_end, n_walk_end;
    logic [7:0]            r_add_tag, n_add_tag;
    logic [COUNT_BITS-1:0] r_add_cd, n_add_cd;
    logic [COUNT_BITS-1:0] r_add_period, n_add_period;

    ptrs_pkg::t_res        r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    logic [15:0]           r_out_pending, n_out_pending;
    logic                  r_out_overrun, n_out_overrun;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_at_end;
    logic                  w_used_here;
    logic [2:0]            w_slot3;
    logic [31:0]           w_idx_ext;
    logic [63:0]           w_pend_ext;
    logic [COUNT_BITS-1:0] w_period_m;
    logic [COUNT_BITS-1:0] w_first_cd;
    logic [COUNT_BITS-1:0] w_cd_dec;
    logic [COUNT_BITS-1:0] w_rd_cd;
    logic [COUNT_BITS-1:0] w_rd_period;
    logic [7:0]            w_rd_tag;
    logic                  w_release;

    logic                  w_ram_we;
    logic [IDX_W-1:0]      w_ram_raddr;
    logic [ENT_W-1:0]      w_ram_wdata;
    logic [ENT_W-1:0]      w_ram_rdata;

    ptrs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_at_end   = (r_idx == IDX_LAST);
    assign w_used_here = r_used[r_idx];
    assign w_idx_ext  = 32'(r_idx);
    assign w_slot3    = w_idx_ext[2:0];
    assign w_period_m = COUNT_BITS'(i_period);
    assign w_first_cd = (64'(i_first_delay) >= 64'(CNT_MAX)) ? CNT_MAX
                        : COUNT_BITS'(i_first_delay) + 1'b1;

    assign w_rd_tag    = w_ram_rdata[ENT_W-1 -: 8];
    assign w_rd_cd     = w_ram_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
    assign w_rd_period = w_ram_rdata[COUNT_BITS-1:0];

    // The one countdown unit shared by every slot of the walk.
    assign w_cd_dec  = w_rd_cd - 1'b1;
    assign w_release = w_used_here && (w_cd_dec == '0);

    // While checking, the next slot is read ahead so the walk keeps one slot a cycle while no result is emitted.
    assign w_ram_raddr = (r_state == ST_CHECK) ? r_idx + 1'b1 : r_idx;

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_wdata = {r_add_tag, r_add_cd, r_add_period};
        if (r_state == ST_FIND) begin
            w_ram_we = !w_used_here;
        end else if (r_state == ST_CHECK) begin
            w_ram_we    = w_used_here;
            w_ram_wdata = {w_rd_tag, (w_release ? w_rd_period : w_cd_dec), w_rd_period};
        end
    end

    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_idx         = r_idx;
        n_pending     = r_pending;
        n_overrun     = r_overrun;
        n_res         = r_res;
        n_hold        = r_hold;
        n_hold_v      = r_hold_v;
        n_walk_end    = r_walk_end;
        n_add_tag     = r_add_tag;
        n_add_cd      = r_add_cd;
        n_add_period  = r_add_period;
        n_out         = r_out;
        n_out_valid   = r_out_valid && i_stall;
        n_out_pending = r_out_pending;
        n_out_overrun = r_out_overrun;
        w_pend_ext    = 64'(r_pending);

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res = '{kind: ptrs_pkg::KIND_ACK, tag: 8'd0, slot: 3'd0, last: 1'b1};
                    n_state = ST_EMIT;
                    unique case (i_command)
                        ptrs_pkg::CMD_TICK: begin
                            if (r_pending != CNT_MAX) begin
                                n_pending = r_pending + 1'b1;
                            end
                            w_pend_ext = 64'(n_pending);
                            if (w_pend_ext > 64'(r_tick_limit)) begin
                                n_overrun = 1'b1;
                            end
                        end
                        ptrs_pkg::CMD_SERVICE: begin
                            if (r_pending == '0) begin
                                n_res.kind = ptrs_pkg::KIND_NONE;
                            end else begin
                                n_pending  = r_pending - 1'b1;
                                n_idx      = '0;
                                n_hold_v   = 1'b0;
                                n_walk_end = 1'b0;
                                n_state    = ST_READ;
                            end
                        end
                        ptrs_pkg::CMD_ADD: begin
                            if (w_period_m == '0) begin
                                n_res = '{kind: ptrs_pkg::KIND_ADD_FAIL, tag: i_task_tag,
                                          slot: 3'd0, last: 1'b1};
                            end else begin
                                n_idx        = '0;
                                n_add_tag    = i_task_tag;
                                n_add_cd     = w_first_cd;
                                n_add_period = w_period_m;
                                n_state      = ST_FIND;
                            end
                        end
                        ptrs_pkg::CMD_RESTART: begin
                            n_pending = '0;
                            n_overrun = 1'b0;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (!w_used_here) begin
                    n_used[r_idx] = 1'b1;
                    n_res = '{kind: ptrs_pkg::KIND_ADD_OK, tag: r_add_tag,
                              slot: w_slot3, last: 1'b1};
                    n_state = ST_EMIT;
                end else if (w_at_end) begin
                    n_res = '{kind: ptrs_pkg::KIND_ADD_FAIL, tag: r_add_tag,
                              slot: 3'd0, last: 1'b1};
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!w_at_end) begin
                    n_idx = r_idx + 1'b1;
                end
                // A release is held back until the walk shows whether it is the final result.
                if (w_release) begin
                    n_hold   = '{kind: ptrs_pkg::KIND_RELEASE, tag: w_rd_tag,
                                 slot: w_slot3, last: 1'b0};
                    n_hold_v = 1'b1;
                    if (r_hold_v) begin
                        n_res      = r_hold;
                        n_walk_end = w_at_end;
                        n_state    = ST_EMIT;
                    end else if (w_at_end) begin
                        n_res      = '{kind: ptrs_pkg::KIND_RELEASE, tag: w_rd_tag,
                                       slot: w_slot3, last: 1'b1};
                        n_state    = ST_EMIT;
                    end
                end else if (w_at_end) begin
                    if (r_hold_v) begin
                        n_res      = r_hold;
                        n_res.last = 1'b1;
                    end else begin
                        n_res = '{kind: ptrs_pkg::KIND_ACK, tag: 8'd0, slot: 3'd0, last: 1'b1};
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out         = r_res;
                    n_out_valid   = 1'b1;
                    n_out_pending = w_pend_ext[15:0];
                    n_out_overrun = r_overrun;
                    if (r_res.last) begin
                        n_state = ST_IDLE;
                    end else if (r_walk_end) begin
                        n_res      = r_hold;
                        n_res.last = 1'b1;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_idx        <= '0;
            r_pending    <= '0;
            r_overrun    <= 1'b0;
            r_tick_limit <= ptrs_pkg::TICK_LIMIT_RST;
            r_hold_v     <= 1'b0;
            r_walk_end   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_pending   <= n_pending;
            r_overrun   <= n_overrun;
            r_hold_v    <= n_hold_v;
            r_walk_end  <= n_walk_end;
            r_out_valid <= n_out_valid;
            if (i_tick_limit_we) begin
                r_tick_limit <= i_tick_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res         <= n_res;
        r_hold        <= n_hold;
        r_add_tag     <= n_add_tag;
        r_add_cd      <= n_add_cd;
        r_add_period  <= n_add_period;
        r_out         <= n_out;
        r_out_pending <= n_out_pending;
        r_out_overrun <= n_out_overrun;
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_task_tag_res = r_out.tag;
    assign o_slot         = r_out.slot;
    assign o_pending      = r_out_pending;
    assign o_overrun      = r_out_overrun;
    assign o_last         = r_out.last;

endmodule

// File: src/ptrs_checker.sv
// Port-level checker of the periodic task release scheduler and its bind statement.
`timescale 1ns / 1ps
`include "periodic_task_release_scheduler_assert.svh"

module ptrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_tick_limit_we,
    input logic [15:0] i_tick_limit,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_command,
    input logic [7:0]  i_task_tag,
    input logic [15:0] i_first_delay,
    input logic [15:0] i_period,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_task_tag_res,
    input logic [2:0]  o_slot,
    input logic [15:0] o_pending,
    input logic        o_overrun,
    input logic        o_last
);

    // A stalled result must stay in place until its transfer.
    `PTRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_kind, o_task_tag_res, o_slot, o_pending, o_overrun, o_last}), "stalled result changed")

    // Acknowledge, nothing-pending and add results are always the single result of their item.
    `PTRS_ASSERT_NOW(a_single_last, i_clk, i_rst_n, o_valid && (o_kind == ptrs_pkg::KIND_ACK || o_kind == ptrs_pkg::KIND_NONE || o_kind == ptrs_pkg::KIND_ADD_OK || o_kind == ptrs_pkg::KIND_ADD_FAIL), o_last, "single result without last")

    // Acknowledge and nothing-pending results carry no tag and no slot.
    `PTRS_ASSERT_NOW(a_ack_empty, i_clk, i_rst_n, o_valid && (o_kind == ptrs_pkg::KIND_ACK || o_kind == ptrs_pkg::KIND_NONE), o_task_tag_res == 8'd0 && o_slot == 3'd0, "acknowledge with tag or slot")

    // Nothing pending means the count shown is zero.
    `PTRS_ASSERT_NOW(a_none_zero, i_clk, i_rst_n, o_valid && o_kind == ptrs_pkg::KIND_NONE, o_pending == 16'd0, "nothing pending with nonzero count")

endmodule

bind periodic_task_release_scheduler ptrs_checker u_ptrs_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the periodic task release scheduler.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  tag;
        logic [15:0] delay;
        logic [15:0] period;
    } t_sched_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tag;
        logic [2:0]  slot;
        logic [15:0] pending;
        logic        overrun;
        logic        last;
    } t_sched_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_tick_limit_we = 1'b0;
    logic [15:0] i_tick_limit = 16'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = ptrs_pkg::CMD_TICK;
    logic [7:0]  i_task_tag = 8'd0;
    logic [15:0] i_first_delay = 16'd0;
    logic [15:0] i_period = 16'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_task_tag_res;
    logic [2:0]  o_slot;
    logic [15:0] o_pending;
    logic        o_overrun;
    logic        o_last;

    periodic_task_release_scheduler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_limit_we(i_tick_limit_we),
        .i_tick_limit   (i_tick_limit),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_task_tag     (i_task_tag),
        .i_first_delay  (i_first_delay),
        .i_period       (i_period),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_task_tag_res (o_task_tag_res),
        .o_slot         (o_slot),
        .o_pending      (o_pending),
        .o_overrun      (o_overrun),
        .o_last         (o_last)
    );

    // Mirror of the scheduler state.
    logic        tbl_used   [8];
    logic [7:0]  tbl_tag    [8];
    logic [15:0] tbl_count  [8];
    logic [15:0] tbl_period [8];
    logic [15:0] ticks_owed   = 16'd0;
    logic        overrun_seen = 1'b0;
    logic [15:0] limit_mirror = ptrs_pkg::TICK_LIMIT_RST;

    t_sched_cmd pending_cmds [$];
    t_sched_res due_results  [$];

    logic in_taken = 1'b0;
    logic tx_idle  = 1'b0;
    logic rx_idle  = 1'b0;
    int   tx_gap   = 0;
    int   rx_hold  = 0;

    int faults         = 0;
    int commands_taken = 0;
    int results_seen   = 0;
    int releases_seen  = 0;
    int peak_releases  = 0;
    int peak_owed      = 0;
    int limit_writes   = 0;

    initial begin
        for (int i = 0; i < 8; i++) begin
            tbl_used[i] = 1'b0;
        end
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void post_result(input logic [2:0] kind, input logic [7:0] tag,
                                        input logic [2:0] slot);
        t_sched_res r;
        r.kind    = kind;
        r.tag     = tag;
        r.slot    = slot;
        r.pending = ticks_owed;
        r.overrun = overrun_seen;
        r.last    = 1'b0;
        due_results.push_back(r);
    endfunction

    // Works out the results of one accepted command and advances the mirrored state.
    function automatic void schedule_command(input t_sched_cmd c);
        int first_free;
        int released;
        int i;
        first_free = -1;
        released   = 0;
        case (c.command)
            ptrs_pkg::CMD_TICK: begin
                if (ticks_owed != 16'hFFFF) ticks_owed = ticks_owed + 16'd1;
                if (ticks_owed > limit_mirror) overrun_seen = 1'b1;
                post_result(ptrs_pkg::KIND_ACK, 8'd0, 3'd0);
            end
            ptrs_pkg::CMD_SERVICE: begin
                if (ticks_owed == 16'd0) begin
                    post_result(ptrs_pkg::KIND_NONE, 8'd0, 3'd0);
                end else begin
                    ticks_owed = ticks_owed - 16'd1;
                    for (i = 0; i < 8; i++) begin
                        if (tbl_used[i]) begin
                            tbl_count[i] = tbl_count[i] - 16'd1;
                            if (tbl_count[i] == 16'd0) begin
                                tbl_count[i] = tbl_period[i];
                                post_result(ptrs_pkg::KIND_RELEASE, tbl_tag[i], 3'(i));
                                released++;
                            end
                        end
                    end
                    if (released == 0) post_result(ptrs_pkg::KIND_ACK, 8'd0, 3'd0);
                    releases_seen += released;
                    if (released > peak_releases) peak_releases = released;
                end
            end
            ptrs_pkg::CMD_ADD: begin
                for (i = 7; i >= 0; i--) begin
                    if (!tbl_used[i]) first_free = i;
                end
                // A full table and a zero period are both reported as a failed add in slot 0.
                if (first_free < 0 || c.period == 16'd0) begin
                    post_result(ptrs_pkg::KIND_ADD_FAIL, c.tag, 3'd0);
                end else begin
                    tbl_used[first_free]   = 1'b1;
                    tbl_tag[first_free]    = c.tag;
                    tbl_count[first_free]  = (c.delay == 16'hFFFF) ? 16'hFFFF : c.delay + 16'd1;
                    tbl_period[first_free] = c.period;
                    post_result(ptrs_pkg::KIND_ADD_OK, c.tag, 3'(first_free));
                end
            end
            default: begin
                ticks_owed   = 16'd0;
                overrun_seen = 1'b0;
                post_result(ptrs_pkg::KIND_ACK, 8'd0, 3'd0);
            end
        endcase
        due_results[due_results.size() - 1].last = 1'b1;
        if (int'(ticks_owed) > peak_owed) peak_owed = int'(ticks_owed);
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    function automatic void queue_cmd(input logic [1:0] command, input logic [7:0] tag,
                                      input logic [15:0] delay, input logic [15:0] period);
        t_sched_cmd c;
        c.command = command;
        c.tag     = tag;
        c.delay   = delay;
        c.period  = period;
        pending_cmds.push_back(c);
    endfunction

    // Mostly small delays and periods so that releases come often; now and then zero
    // periods, periods across the whole range and delays up to 65534.
    function automatic t_sched_cmd random_command();
        t_sched_cmd c;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) c.command = ptrs_pkg::CMD_TICK;
        else if (pick < 15) c.command = ptrs_pkg::CMD_SERVICE;
        else if (pick < 18) c.command = ptrs_pkg::CMD_ADD;
        else c.command = ptrs_pkg::CMD_RESTART;
        c.tag = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) c.delay = 16'($urandom_range(0, 65534));
        else c.delay = 16'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick == 0) c.period = 16'd0;
        else if (pick == 1) c.period = 16'($urandom_range(0, 65535));
        else c.period = 16'($urandom_range(1, 6));
        return c;
    endfunction

    // Driver: presents commands and drives the result-side stall.
    always @(negedge i_clk) begin
        t_sched_cmd next_cmd;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            // A payload stays put until its transfer has happened.
            if (!i_valid || in_taken) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (tx_idle && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 13);
                    i_valid <= 1'b0;
                end else begin
                    next_cmd = pending_cmds.pop_front();
                    i_valid       <= 1'b1;
                    i_command     <= next_cmd.command;
                    i_task_tag    <= next_cmd.tag;
                    i_first_delay <= next_cmd.delay;
                    i_period      <= next_cmd.period;
                end
            end
            in_taken = 1'b0;
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                rx_hold = $urandom_range(0, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Monitor: checks results, mirrors register writes and predicts each accepted command.
    always @(posedge i_clk) begin
        t_sched_res want;
        t_sched_cmd seen;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result with no expectation: kind %0d tag %0d slot %0d",
                           o_kind, o_task_tag_res, o_slot);
                    faults++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(o_kind));
                    compare_field("task_tag_res", 16'(want.tag), 16'(o_task_tag_res));
                    compare_field("slot", 16'(want.slot), 16'(o_slot));
                    compare_field("pending", want.pending, o_pending);
                    compare_field("overrun", 16'(want.overrun), 16'(o_overrun));
                    compare_field("last", 16'(want.last), 16'(o_last));
                end
            end
            if (i_tick_limit_we) begin
                limit_mirror = i_tick_limit;
                limit_writes++;
            end
            if (i_valid && !o_stall) begin
                seen.command = i_command;
                seen.tag     = i_task_tag;
                seen.delay   = i_first_delay;
                seen.period  = i_period;
                schedule_command(seen);
                commands_taken++;
                in_taken = 1'b1;
            end
        end
    end

    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_cmds.size() != 0 || i_valid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_tick_limit(input logic [15:0] value);
        wait_quiet();
        i_tick_limit_we <= 1'b1;
        i_tick_limit    <= value;
        @(negedge i_clk);
        i_tick_limit_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] limit_values [5];
        int phase;
        limit_values[0] = 16'd0;
        limit_values[1] = 16'hFFFF;
        limit_values[2] = 16'd3;
        limit_values[3] = 16'($urandom_range(1, 65534));
        limit_values[4] = ptrs_pkg::TICK_LIMIT_RST;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        queue_cmd(ptrs_pkg::CMD_SERVICE, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_RESTART, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'hA5, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'hFF, 16'd65534, 16'hFFFF);
        // With only the long task in the table a service releases nothing.
        queue_cmd(ptrs_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_SERVICE, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h00, 16'd0, 16'd1);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h11, 16'd1, 16'd2);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h22, 16'd0, 16'd1);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h33, 16'd2, 16'd3);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h44, 16'd0, 16'd1);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h55, 16'd0, 16'd1);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h66, 16'd0, 16'd1);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h77, 16'd3, 16'd5);
        queue_cmd(ptrs_pkg::CMD_ADD, 8'h5A, 16'd0, 16'd0);
        repeat (3) queue_cmd(ptrs_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
        repeat (4) queue_cmd(ptrs_pkg::CMD_SERVICE, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_RESTART, 8'd0, 16'd0, 16'd0);

        for (phase = 0; phase < 5; phase++) begin
            set_tick_limit(limit_values[phase]);
            tx_idle = (phase != 1) && (phase != 3);
            rx_idle = (phase != 1) && (phase != 2);
            repeat (75) pending_cmds.push_back(random_command());
        end

        // Closing stretch without idling: a low limit so the flag sets, then a restart clears it.
        set_tick_limit(16'd2);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        tx_gap  = 0;
        rx_hold = 0;
        queue_cmd(ptrs_pkg::CMD_RESTART, 8'd0, 16'd0, 16'd0);
        repeat (6) queue_cmd(ptrs_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
        repeat (3) queue_cmd(ptrs_pkg::CMD_SERVICE, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_RESTART, 8'd0, 16'd0, 16'd0);
        queue_cmd(ptrs_pkg::CMD_SERVICE, 8'd0, 16'd0, 16'd0);
        repeat (2) queue_cmd(ptrs_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
        repeat (2) queue_cmd(ptrs_pkg::CMD_SERVICE, 8'd0, 16'd0, 16'd0);

        wait_quiet();
        repeat (40) @(posedge i_clk);
        #1;
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            faults++;
        end
        $display("Summary: %0d commands taken, %0d results compared, %0d task releases",
                 commands_taken, results_seen, releases_seen);
        $display("Summary: up to %0d releases per service, peak pending count %0d, %0d limit writes",
                 peak_releases, peak_owed, limit_writes);
        if (faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
